@@ hw/rtl/cel_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package cel_pkg;

  // field widths
  localparam int DLEN_W  = 17;
  localparam int CODE_W  = 5;
  localparam int BTN_W   = 8;
  localparam int DELAY_W = 24;
  localparam int CFG_W   = 17;
  localparam int CIDX_W  = 2;

  // event byte layout
  localparam int EV_CMD_FLAG = 7;

  // input operation codes
  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_RESTART = 2'd1,
    OP_FRAME   = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  // frame command codes
  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_RESET = 2'd1,
    CMD_POWER = 2'd2
  } cmd_t;

  // configuration register indexes
  typedef enum logic [CIDX_W-1:0] {
    CFG_DATA_LENGTH      = 2'd0,
    CFG_START_WITH_RESET = 2'd1,
    CFG_RESET_CODE       = 2'd2,
    CFG_POWER_CODE       = 2'd3
  } cfg_idx_t;

  // walker sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_EV,
    S_DLY_REQ,
    S_DLY_DATA,
    S_FIX_REQ,
    S_FIX_DATA,
    S_COMMIT,
    S_FINISH
  } seq_state_t;

  // configuration bundle
  typedef struct packed {
    logic [DLEN_W-1:0] data_length;
    logic              start_with_reset;
    logic [CODE_W-1:0] reset_code;
    logic [CODE_W-1:0] power_code;
  } cfg_t;

  // request into the walker
  typedef struct packed {
    logic start;
    logic restart;
  } seq_ctrl_t;

  // one frame record
  typedef struct packed {
    logic [BTN_W-1:0] p1;
    logic [BTN_W-1:0] p2;
    logic [BTN_W-1:0] p3;
    logic [BTN_W-1:0] p4;
    cmd_t             cmd;
    logic             exhausted;
    logic             extra;
  } rec_t;

endpackage

`default_nettype wire

@@ hw/rtl/cel_store.sv @@
`timescale 1ns / 1ps
`default_nettype none

module cel_store #(
  parameter int STORE_DEPTH = 65536
) (
  input  wire logic                           clk,
  input  wire logic                           we,
  input  wire logic [$clog2(STORE_DEPTH)-1:0] wa,
  input  wire logic [cel_pkg::BTN_W-1:0]      wd,
  input  wire logic                           re,
  input  wire logic [$clog2(STORE_DEPTH)-1:0] ra,
  output logic      [cel_pkg::BTN_W-1:0]      rd
);

  logic [cel_pkg::BTN_W-1:0] mem [STORE_DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rd <= mem[ra];
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/cel_seq.sv @@
`timescale 1ns / 1ps
`default_nettype none

module cel_seq #(
  parameter int STORE_DEPTH = 65536
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire cel_pkg::seq_ctrl_t             ctrl,
  input  wire cel_pkg::cfg_t                  cfg,
  input  wire logic                           out_free,
  input  wire logic [cel_pkg::BTN_W-1:0]      rd_data,
  output logic                                rd_en,
  output logic      [$clog2(STORE_DEPTH)-1:0] rd_addr,
  output logic                                busy,
  output logic                                rec_push,
  output cel_pkg::rec_t                       rec
);

  localparam int AW = $clog2(STORE_DEPTH);
  localparam int PW = (AW + 1 > cel_pkg::DLEN_W) ? AW + 1 : cel_pkg::DLEN_W;
  localparam int BW = cel_pkg::BTN_W;
  localparam int DW = cel_pkg::DELAY_W;

  cel_pkg::seq_state_t state_r, state_nxt;
  logic [PW-1:0]       pos_r, pos_nxt;
  logic [BW-1:0]       btn_r [4];
  logic [BW-1:0]       btn_nxt [4];
  logic [DW-1:0]       frames_r, frames_nxt;
  logic [DW-1:0]       pdelay_r, pdelay_nxt;
  logic [BW-1:0]       pevent_r, pevent_nxt;
  logic                pvalid_r, pvalid_nxt;
  logic                first_r, first_nxt;
  logic                end_r, end_nxt;
  logic [BW-1:0]       pmask_r, pmask_nxt;
  cel_pkg::cmd_t       cmd_r, cmd_nxt;
  logic [BW-1:0]       ev_r, ev_nxt;
  logic [DW-1:0]       delay_r, delay_nxt;
  logic [1:0]          idx_r, idx_nxt;

  logic [PW-1:0] dlen_ext;
  logic [PW-1:0] depth_ext;
  logic [PW-1:0] limit;
  logic          fetch_ok;
  logic [1:0]    cnt;
  logic [BW-1:0] mask_now;

  // shared byte fetch unit: bound compare against the smaller of the data length and the store depth
  assign dlen_ext  = PW'(cfg.data_length);
  assign depth_ext = PW'(STORE_DEPTH);
  assign limit     = (dlen_ext < depth_ext) ? dlen_ext : depth_ext;
  assign fetch_ok  = (pos_r < limit);
  assign rd_addr   = pos_r[AW-1:0];

  assign cnt      = ev_r[6:5];
  assign mask_now = pmask_r | btn_r[2] | btn_r[3];
  assign busy     = (state_r != cel_pkg::S_IDLE);

  // frame record from the live state
  assign rec.p1        = btn_r[0];
  assign rec.p2        = btn_r[1];
  assign rec.p3        = btn_r[2];
  assign rec.p4        = btn_r[3];
  assign rec.cmd       = cmd_r;
  assign rec.exhausted = end_r;
  assign rec.extra     = (mask_now != '0);

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= cel_pkg::S_IDLE;
      pos_r    <= '0;
      btn_r    <= '{default: '0};
      frames_r <= '0;
      pdelay_r <= '0;
      pevent_r <= '0;
      pvalid_r <= 1'b0;
      first_r  <= 1'b1;
      end_r    <= 1'b0;
      pmask_r  <= '0;
      cmd_r    <= cel_pkg::CMD_NONE;
    end else begin
      state_r  <= state_nxt;
      pos_r    <= pos_nxt;
      btn_r    <= btn_nxt;
      frames_r <= frames_nxt;
      pdelay_r <= pdelay_nxt;
      pevent_r <= pevent_nxt;
      pvalid_r <= pvalid_nxt;
      first_r  <= first_nxt;
      end_r    <= end_nxt;
      pmask_r  <= pmask_nxt;
      cmd_r    <= cmd_nxt;
    end
  end

  // event scratch registers
  always_ff @(posedge clk) begin
    ev_r    <= ev_nxt;
    delay_r <= delay_nxt;
    idx_r   <= idx_nxt;
  end

  // sequencer: next state and datapath
  always_comb begin
    state_nxt  = state_r;
    pos_nxt    = pos_r;
    btn_nxt    = btn_r;
    frames_nxt = frames_r;
    pdelay_nxt = pdelay_r;
    pevent_nxt = pevent_r;
    pvalid_nxt = pvalid_r;
    first_nxt  = first_r;
    end_nxt    = end_r;
    pmask_nxt  = pmask_r;
    cmd_nxt    = cmd_r;
    ev_nxt     = ev_r;
    delay_nxt  = delay_r;
    idx_nxt    = idx_r;
    rd_en      = 1'b0;
    rec_push   = 1'b0;

    unique case (state_r)
      cel_pkg::S_IDLE: begin
        if (ctrl.restart) begin
          pos_nxt    = '0;
          btn_nxt    = '{default: '0};
          frames_nxt = '0;
          pdelay_nxt = '0;
          pevent_nxt = '0;
          pvalid_nxt = 1'b0;
          first_nxt  = 1'b1;
          end_nxt    = 1'b0;
          pmask_nxt  = '0;
        end else if (ctrl.start) begin
          cmd_nxt   = (first_r && cfg.start_with_reset) ? cel_pkg::CMD_RESET
                                                        : cel_pkg::CMD_NONE;
          first_nxt = 1'b0;
          state_nxt = cel_pkg::S_CHECK;
        end
      end

      // event due test, apply pending event, fetch next event byte
      cel_pkg::S_CHECK: begin
        if (end_r || (pvalid_r && (pdelay_r != frames_r))) begin
          state_nxt = cel_pkg::S_FINISH;
        end else begin
          if (pvalid_r) begin
            if (pevent_r[cel_pkg::EV_CMD_FLAG]) begin
              if (pevent_r[4:0] == cfg.reset_code) begin
                cmd_nxt = cel_pkg::CMD_RESET;
              end
              if (pevent_r[4:0] == cfg.power_code) begin
                cmd_nxt = cel_pkg::CMD_POWER;
              end
            end else begin
              btn_nxt[pevent_r[4:3]] = btn_r[pevent_r[4:3]] ^ (BW'(1) << pevent_r[2:0]);
            end
          end
          if (!fetch_ok) begin
            end_nxt    = 1'b1;
            pvalid_nxt = 1'b0;
            state_nxt  = cel_pkg::S_FINISH;
          end else begin
            rd_en     = 1'b1;
            pos_nxt   = pos_r + PW'(1);
            state_nxt = cel_pkg::S_EV;
          end
        end
      end

      cel_pkg::S_EV: begin
        ev_nxt    = rd_data;
        delay_nxt = '0;
        idx_nxt   = '0;
        state_nxt = (rd_data[6:5] == 2'd0) ? cel_pkg::S_COMMIT : cel_pkg::S_DLY_REQ;
      end

      // little-endian delay bytes
      cel_pkg::S_DLY_REQ: begin
        if (idx_r == cnt) begin
          if ((delay_r == '0) && ((cnt == 2'd1) || (cnt == 2'd2))) begin
            state_nxt = cel_pkg::S_FIX_REQ;
          end else begin
            state_nxt = cel_pkg::S_COMMIT;
          end
        end else if (!fetch_ok) begin
          end_nxt    = 1'b1;
          pvalid_nxt = 1'b0;
          state_nxt  = cel_pkg::S_FINISH;
        end else begin
          rd_en     = 1'b1;
          pos_nxt   = pos_r + PW'(1);
          state_nxt = cel_pkg::S_DLY_DATA;
        end
      end

      cel_pkg::S_DLY_DATA: begin
        unique case (idx_r)
          2'd0:    delay_nxt[7:0]   = rd_data;
          2'd1:    delay_nxt[15:8]  = rd_data;
          default: delay_nxt[23:16] = rd_data;
        endcase
        idx_nxt   = idx_r + 2'd1;
        state_nxt = cel_pkg::S_DLY_REQ;
      end

      // legacy zero-delay fix byte
      cel_pkg::S_FIX_REQ: begin
        if (!fetch_ok) begin
          end_nxt    = 1'b1;
          pvalid_nxt = 1'b0;
          state_nxt  = cel_pkg::S_FINISH;
        end else begin
          rd_en     = 1'b1;
          pos_nxt   = pos_r + PW'(1);
          state_nxt = cel_pkg::S_FIX_DATA;
        end
      end

      cel_pkg::S_FIX_DATA: begin
        delay_nxt = (cnt == 2'd1) ? {8'd0, rd_data, 8'd0} : {rd_data, 16'd0};
        state_nxt = cel_pkg::S_COMMIT;
      end

      cel_pkg::S_COMMIT: begin
        if (pvalid_r) begin
          frames_nxt = '0;
        end
        pevent_nxt = ev_r;
        pdelay_nxt = delay_r;
        pvalid_nxt = 1'b1;
        state_nxt  = cel_pkg::S_CHECK;
      end

      // hand the record over once the output register is free
      cel_pkg::S_FINISH: begin
        if (out_free) begin
          rec_push  = 1'b1;
          pmask_nxt = mask_now;
          if (!end_r) begin
            frames_nxt = frames_r + DW'(1);
          end
          state_nxt = cel_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = cel_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ hw/rtl/controller_event_log_decoder.sv @@
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake          payload
// in_       input      in_valid/in_stall  operation, load_address, load_byte
// out_      output     out_valid/out_stall four button bytes, command, flags
// cfg_      input      cfg_valid/cfg_ready register index, write data
//
// load and restart requests are taken when in_stall is low and give no result.
// a frame request keeps in_stall high while the walker reads event, delay and
// fix bytes, all through the single store read port with its registered read data.
// rst_n is synchronous; the store is not cleared and must be loaded first.
// in_stall also stays high while a record waits behind a stalled output register.

module controller_event_log_decoder #(
  parameter int STORE_DEPTH = 65536
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [1:0]                     in_operation,
  input  wire logic [15:0]                    in_load_address,
  input  wire logic [cel_pkg::BTN_W-1:0]      in_load_byte,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic      [cel_pkg::BTN_W-1:0]      out_player1_buttons,
  output logic      [cel_pkg::BTN_W-1:0]      out_player2_buttons,
  output logic      [cel_pkg::BTN_W-1:0]      out_player3_buttons,
  output logic      [cel_pkg::BTN_W-1:0]      out_player4_buttons,
  output logic      [1:0]                     out_frame_command,
  output logic                                out_data_exhausted,
  output logic                                out_extra_players_seen,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [cel_pkg::CIDX_W-1:0]     cfg_index,
  input  wire logic [cel_pkg::CFG_W-1:0]      cfg_data
);

  localparam int AW = $clog2(STORE_DEPTH);
  localparam int PW = (AW + 1 > cel_pkg::DLEN_W) ? AW + 1 : cel_pkg::DLEN_W;

  cel_pkg::cfg_t      cfg_r;
  cel_pkg::seq_ctrl_t ctrl;
  cel_pkg::rec_t      rec;
  cel_pkg::rec_t      out_rec_r;
  cel_pkg::op_t       op;
  logic               out_valid_r, out_valid_nxt;
  logic               in_acc;
  logic               seq_busy;
  logic               rec_push;
  logic               out_free;
  logic [PW-1:0]      wa_ext;
  logic               st_we;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic [cel_pkg::BTN_W-1:0] rd_data;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.data_length      <= '0;
      cfg_r.start_with_reset <= 1'b0;
      cfg_r.reset_code       <= '0;
      cfg_r.power_code       <= cel_pkg::CODE_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cel_pkg::cfg_idx_t'(cfg_index))
        cel_pkg::CFG_DATA_LENGTH:      cfg_r.data_length      <= cfg_data[cel_pkg::DLEN_W-1:0];
        cel_pkg::CFG_START_WITH_RESET: cfg_r.start_with_reset <= cfg_data[0];
        cel_pkg::CFG_RESET_CODE:       cfg_r.reset_code       <= cfg_data[cel_pkg::CODE_W-1:0];
        cel_pkg::CFG_POWER_CODE:       cfg_r.power_code       <= cfg_data[cel_pkg::CODE_W-1:0];
        default: ;
      endcase
    end
  end

  // input request decode
  assign op        = cel_pkg::op_t'(in_operation);
  assign in_stall  = seq_busy;
  assign in_acc    = in_valid && !in_stall;
  assign ctrl.start   = in_acc && (op == cel_pkg::OP_FRAME);
  assign ctrl.restart = in_acc && (op == cel_pkg::OP_RESTART);

  // load writes go straight to the store when the address fits
  assign wa_ext = PW'(in_load_address);
  assign st_we  = in_acc && (op == cel_pkg::OP_LOAD) && (wa_ext < PW'(STORE_DEPTH));

  cel_store #(
    .STORE_DEPTH(STORE_DEPTH)
  ) u_store (
    .clk (clk),
    .we  (st_we),
    .wa  (wa_ext[AW-1:0]),
    .wd  (in_load_byte),
    .re  (rd_en),
    .ra  (rd_addr),
    .rd  (rd_data)
  );

  cel_seq #(
    .STORE_DEPTH(STORE_DEPTH)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (ctrl),
    .cfg      (cfg_r),
    .out_free (out_free),
    .rd_data  (rd_data),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .busy     (seq_busy),
    .rec_push (rec_push),
    .rec      (rec)
  );

  // output register
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (rec_push) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rec_push) begin
      out_rec_r <= rec;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_player1_buttons    = out_rec_r.p1;
  assign out_player2_buttons    = out_rec_r.p2;
  assign out_player3_buttons    = out_rec_r.p3;
  assign out_player4_buttons    = out_rec_r.p4;
  assign out_frame_command      = out_rec_r.cmd;
  assign out_data_exhausted     = out_rec_r.exhausted;
  assign out_extra_players_seen = out_rec_r.extra;

  // a record is never pushed over one still waiting
  a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
    rec_push |-> (!out_valid_r || !out_stall))
    else $error("record pushed while output register blocked");

  // an accepted frame request starts the walker
  a_frame_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && (in_operation == cel_pkg::OP_FRAME)) |=> seq_busy)
    else $error("frame request did not start the walker");

  // a new result only appears after a record push
  a_out_from_push: assert property (@(posedge clk) disable iff (!rst_n)
    (!$past(out_valid_r) || !$past(out_stall)) && out_valid_r |-> $past(rec_push))
    else $error("result appeared without a record push");

  // store reads only happen while a frame is walking
  a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> seq_busy)
    else $error("store read outside a frame walk");

endmodule

`default_nettype wire
